// ===== hw/rtl/bla_pkg.sv =====
// bla_pkg: shared widths, limits, register indexes and stage structs for the
// blocked lagged autocorrelation pipeline. No dependencies.
package bla_pkg;

    localparam int MAX_LAG       = 64;
    localparam int MAX_LOG_BLOCK = 24;

    localparam int LAG_W   = 7;                    // lag register
    localparam int LOGB_W  = 5;                    // log_block register
    localparam int TAP_W   = $clog2(MAX_LAG);      // delay line index
    localparam int POS_W   = 48;                   // sample position
    localparam int ACC_W   = 26;                   // block sum, signed
    localparam int ABS_W   = 25;                   // |block sum|
    localparam int CNT_W   = 24;                   // block number, counters
    localparam int JJ_W    = 10;                   // j*j, j <= 24
    localparam int EXC_W   = ABS_W + JJ_W;         // |C|*j*j
    localparam int SQ_W    = 2 * ABS_W;            // C*C
    localparam int TOT_W   = 64;                   // sum of squares
    localparam int CFG_W   = 7;                    // config write data
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_BLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG       = 1'b1;

    localparam logic [LOGB_W-1:0] LOG_BLOCK_RESET = 5'd16;
    localparam logic [LAG_W-1:0]  LAG_RESET       = 7'd2;

    // closed block, front -> measure
    typedef struct packed {
        logic [CNT_W-1:0]         block_number;
        logic signed [ACC_W-1:0]  block_sum;
        logic [LOGB_W-1:0]        log_block;
    } bla_evt_t;

    // measured block, measure -> stats
    typedef struct packed {
        logic [CNT_W-1:0]         block_number;
        logic signed [ACC_W-1:0]  block_sum;
        logic [ABS_W-1:0]         abs_sum;
        logic                     exceeds;
        logic [SQ_W-1:0]          square;
    } bla_meas_t;

    // result word fields
    typedef struct packed {
        logic [TOT_W-1:0]         sum_of_squares;
        logic                     all_within;
        logic [CNT_W-1:0]         exceed_count;
        logic [ABS_W-1:0]         max_abs_sum;
        logic                     block_exceeds;
        logic signed [ACC_W-1:0]  block_sum;
        logic [CNT_W-1:0]         block_number;
    } bla_res_t;

endpackage

// ===== hw/rtl/block_lag_autocorrelation.sv =====
// block_lag_autocorrelation: top level, configuration registers and stream
// ports around bla_front, bla_measure and bla_stats. Uses bla_pkg.
//
//   channel   dir   handshake               word
//   s_        in    s_tvalid / s_tready     sample
//   m_        out   m_tvalid / m_tready     one closed block with running stats
//   cfg_      in    cfg_valid / cfg_ready   register index, write data
//
// One sample per cycle. A result passes through the event, measure and result
// registers in turn, the event register loading on the edge that accepts the
// sample closing its block.
// Reset (aresetn low, synchronous) clears the delay line, position,
// accumulator and running statistics and loads log_block 16, lag 2.
// A stalled result blocks only the sample that closes the next block once
// the event and measure registers are full; other samples keep flowing.
module block_lag_autocorrelation (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [1:0] sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [23:0] block_number, [49:24] block_sum, [50] block_exceeds,
    // [75:51] max_abs_sum, [99:76] exceed_count, [100] all_within,
    // [164:101] sum_of_squares
    output logic [167:0]                       m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bla_pkg::CFG_W-1:0]          cfg_data
);

    logic [bla_pkg::LOGB_W-1:0] log_block_reg;
    logic [bla_pkg::LAG_W-1:0]  lag_reg;
    logic [bla_pkg::LOGB_W-1:0] log_block_eff;
    logic [bla_pkg::LAG_W-1:0]  lag_eff;

    logic                       evt_valid;
    logic                       evt_ready;
    bla_pkg::bla_evt_t          evt;
    logic                       meas_valid;
    logic                       meas_ready;
    bla_pkg::bla_meas_t         meas;
    bla_pkg::bla_res_t          res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_block_reg <= bla_pkg::LOG_BLOCK_RESET;
            lag_reg       <= bla_pkg::LAG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bla_pkg::CFG_LOG_BLOCK: log_block_reg <= cfg_data[bla_pkg::LOGB_W-1:0];
                bla_pkg::CFG_LAG:       lag_reg       <= cfg_data[bla_pkg::LAG_W-1:0];
                default: ;
            endcase
        end
    end

    assign log_block_eff = (log_block_reg > bla_pkg::LOGB_W'(bla_pkg::MAX_LOG_BLOCK))
                           ? bla_pkg::LOGB_W'(bla_pkg::MAX_LOG_BLOCK) : log_block_reg;
    assign lag_eff       = (lag_reg > bla_pkg::LAG_W'(bla_pkg::MAX_LAG))
                           ? bla_pkg::LAG_W'(bla_pkg::MAX_LAG) : lag_reg;

    bla_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .lag_eff       (lag_eff),
        .log_block_eff (log_block_eff),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_sample     (s_tdata[1:0]),
        .evt_valid     (evt_valid),
        .evt_ready     (evt_ready),
        .evt           (evt)
    );

    bla_measure u_measure (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas       (meas)
    );

    bla_stats u_stats (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas       (meas),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    assign m_tdata = {3'b000, res};

endmodule

// ===== hw/rtl/bla_front.sv =====
// bla_front: delay line, sample position and block accumulator; hands a closed
// block to the next stage through its event register. Uses bla_pkg.
module bla_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bla_pkg::LAG_W-1:0]     lag_eff,
    input  logic [bla_pkg::LOGB_W-1:0]    log_block_eff,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_sample,
    output logic                          evt_valid,
    input  logic                          evt_ready,
    output bla_pkg::bla_evt_t             evt
);

    logic signed [1:0]                  delay_reg [bla_pkg::MAX_LAG];
    logic [bla_pkg::POS_W-1:0]          pos_reg;
    logic signed [bla_pkg::ACC_W-1:0]   acc_reg;
    logic                               evt_valid_reg;
    bla_pkg::bla_evt_t                  evt_reg;

    localparam logic signed [bla_pkg::ACC_W-1:0] ACC_CEIL  = 26'sd16777216;
    localparam logic signed [bla_pkg::ACC_W-1:0] ACC_FLOOR = -26'sd16777216;

    logic [bla_pkg::LAG_W-1:0]          tap;
    logic [bla_pkg::POS_W-1:0]          n_pos;
    logic [bla_pkg::POS_W-1:0]          k_full;
    logic [bla_pkg::CNT_W:0]            mask_full;
    logic [bla_pkg::CNT_W-1:0]          k_sat;
    logic                               formed;
    logic                               in_block;
    logic                               last_pos;
    logic                               will_emit;
    logic                               accept;
    logic signed [1:0]                  v;
    logic signed [1:0]                  earlier;
    logic signed [1:0]                  prod;
    logic signed [bla_pkg::ACC_W-1:0]   acc_sum;
    logic signed [bla_pkg::ACC_W-1:0]   acc_next;

    // everything that decides a block close comes from state, not data
    assign formed    = pos_reg >= {{(bla_pkg::POS_W-bla_pkg::LAG_W){1'b0}}, lag_eff};
    assign n_pos     = pos_reg - {{(bla_pkg::POS_W-bla_pkg::LAG_W){1'b0}}, lag_eff};
    assign k_full    = n_pos >> log_block_eff;
    assign in_block  = formed && (k_full != '0);
    assign mask_full = ((bla_pkg::CNT_W+1)'(1) << log_block_eff) - (bla_pkg::CNT_W+1)'(1);
    assign last_pos  = (n_pos[bla_pkg::CNT_W-1:0] & mask_full[bla_pkg::CNT_W-1:0])
                       == mask_full[bla_pkg::CNT_W-1:0];
    assign will_emit = in_block && last_pos;
    assign k_sat     = (k_full[bla_pkg::POS_W-1:bla_pkg::CNT_W] != '0) ? bla_pkg::CNT_MAX
                       : k_full[bla_pkg::CNT_W-1:0];

    // only the block-closing word needs a free event slot
    assign in_ready = !will_emit || !evt_valid_reg || evt_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin
        case (in_sample)
            2'b00:   v = 2'sd0;
            2'b01:   v = 2'sd1;
            default: v = -2'sd1;
        endcase
    end

    assign tap     = lag_eff - bla_pkg::LAG_W'(1);
    assign earlier = (lag_eff == '0) ? v : delay_reg[tap[bla_pkg::TAP_W-1:0]];

    always_comb begin
        if (earlier == 2'sd0 || v == 2'sd0) begin
            prod = 2'sd0;
        end else if (earlier == v) begin
            prod = 2'sd1;
        end else begin
            prod = -2'sd1;
        end
    end

    assign acc_sum = acc_reg + {{(bla_pkg::ACC_W-2){prod[1]}}, prod};

    always_comb begin
        if (acc_sum > ACC_CEIL) begin
            acc_next = ACC_CEIL;
        end else if (acc_sum < ACC_FLOOR) begin
            acc_next = ACC_FLOOR;
        end else begin
            acc_next = acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bla_pkg::MAX_LAG; i++) begin
                delay_reg[i] <= 2'sd0;
            end
            pos_reg       <= '0;
            acc_reg       <= '0;
            evt_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                delay_reg[0] <= v;
                for (int i = 1; i < bla_pkg::MAX_LAG; i++) begin
                    delay_reg[i] <= delay_reg[i-1];
                end
                pos_reg <= pos_reg + bla_pkg::POS_W'(1);
                if (in_block) begin
                    acc_reg <= will_emit ? '0 : acc_next;
                end
            end
            if (accept && will_emit) begin
                evt_valid_reg <= 1'b1;
            end else if (evt_ready) begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && will_emit) begin
            evt_reg.block_number <= k_sat;
            evt_reg.block_sum    <= acc_next;
            evt_reg.log_block    <= log_block_eff;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

// ===== hw/rtl/bla_measure.sv =====
// bla_measure: absolute value, square and exact exceed test of a closed block
// sum, one register stage. Uses bla_pkg.
module bla_measure (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                evt_valid,
    output logic                evt_ready,
    input  bla_pkg::bla_evt_t   evt,
    output logic                meas_valid,
    input  logic                meas_ready,
    output bla_pkg::bla_meas_t  meas
);

    logic                       meas_valid_reg;
    bla_pkg::bla_meas_t         meas_reg;

    logic signed [bla_pkg::ACC_W-1:0] neg_sum;
    logic [bla_pkg::ABS_W-1:0]  abs_sum;
    logic [bla_pkg::JJ_W-1:0]   jj;
    logic [bla_pkg::EXC_W-1:0]  scaled;
    logic [bla_pkg::EXC_W-1:0]  block_len;
    logic                       load;

    assign neg_sum   = -evt.block_sum;
    assign abs_sum   = evt.block_sum[bla_pkg::ACC_W-1] ? neg_sum[bla_pkg::ABS_W-1:0]
                       : evt.block_sum[bla_pkg::ABS_W-1:0];
    assign jj        = bla_pkg::JJ_W'(evt.log_block) * bla_pkg::JJ_W'(evt.log_block);
    assign scaled    = bla_pkg::EXC_W'(abs_sum) * bla_pkg::EXC_W'(jj);
    assign block_len = bla_pkg::EXC_W'(1) << evt.log_block;

    assign evt_ready = !meas_valid_reg || meas_ready;
    assign load      = evt_valid && evt_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_valid_reg <= 1'b0;
        end else if (evt_ready) begin
            meas_valid_reg <= evt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            meas_reg.block_number <= evt.block_number;
            meas_reg.block_sum    <= evt.block_sum;
            meas_reg.abs_sum      <= abs_sum;
            meas_reg.exceeds      <= scaled > block_len;
            meas_reg.square       <= bla_pkg::SQ_W'(abs_sum) * bla_pkg::SQ_W'(abs_sum);
        end
    end

    assign meas_valid = meas_valid_reg;
    assign meas       = meas_reg;

endmodule

// ===== hw/rtl/bla_stats.sv =====
// bla_stats: running maximum, exceed count and saturating square total, and
// the result register. Uses bla_pkg.
module bla_stats (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                meas_valid,
    output logic                meas_ready,
    input  bla_pkg::bla_meas_t  meas,
    output logic                res_valid,
    input  logic                res_ready,
    output bla_pkg::bla_res_t   res
);

    logic [bla_pkg::ABS_W-1:0]  max_reg;
    logic [bla_pkg::CNT_W-1:0]  exc_cnt_reg;
    logic [bla_pkg::TOT_W-1:0]  total_reg;
    logic                       res_valid_reg;
    bla_pkg::bla_res_t          res_reg;

    logic [bla_pkg::ABS_W-1:0]  max_next;
    logic [bla_pkg::CNT_W-1:0]  exc_cnt_next;
    logic [bla_pkg::TOT_W:0]    total_sum;
    logic [bla_pkg::TOT_W-1:0]  total_next;
    logic                       load;

    assign meas_ready = !res_valid_reg || res_ready;
    assign load       = meas_valid && meas_ready;

    assign max_next     = (meas.abs_sum > max_reg) ? meas.abs_sum : max_reg;
    assign exc_cnt_next = (meas.exceeds && exc_cnt_reg != bla_pkg::CNT_MAX)
                          ? exc_cnt_reg + bla_pkg::CNT_W'(1) : exc_cnt_reg;
    assign total_sum    = {1'b0, total_reg} + (bla_pkg::TOT_W+1)'(meas.square);
    assign total_next   = total_sum[bla_pkg::TOT_W] ? bla_pkg::TOT_MAX
                          : total_sum[bla_pkg::TOT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg       <= '0;
            exc_cnt_reg   <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            if (meas_ready) begin
                res_valid_reg <= meas_valid;
            end
            if (load) begin
                max_reg     <= max_next;
                exc_cnt_reg <= exc_cnt_next;
                total_reg   <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg.block_number   <= meas.block_number;
            res_reg.block_sum      <= meas.block_sum;
            res_reg.block_exceeds  <= meas.exceeds;
            res_reg.max_abs_sum    <= max_next;
            res_reg.exceed_count   <= exc_cnt_next;
            res_reg.all_within     <= exc_cnt_next == '0;
            res_reg.sum_of_squares <= total_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
